>>> src/bom_sniffing_utf16_to_utf8_assert.svh
// ----------------------------------------------------------------------------
// BOM sniffing transcoder assertion macros
// Shared concurrent check macros, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BOM_SNIFFING_UTF16_TO_UTF8_ASSERT_SVH
`define BOM_SNIFFING_UTF16_TO_UTF8_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> src/bsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BOM sniffing transcoder package
// Shared constants, the queued result bundle and the UTF-8 encoder.
// ----------------------------------------------------------------------------
package bsu_pkg;

  localparam int unsigned FifoDepth = 2;

  localparam logic [7:0] BOM_EF = 8'hEF;
  localparam logic [7:0] BOM_BB = 8'hBB;
  localparam logic [7:0] BOM_BF = 8'hBF;
  localparam logic [7:0] BOM_FE = 8'hFE;
  localparam logic [7:0] BOM_FF = 8'hFF;

  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;
  localparam logic [5:0]  HIGH_SURR_TAG  = 6'b110110;
  localparam logic [5:0]  LOW_SURR_TAG   = 6'b110111;

  // bytes[0] goes out first; cnt is 1..4
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            data;
    logic            last;
  } bundle_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } enc_t;

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp[20:7] == '0) begin
      e.bytes[0] = cp[7:0];
      e.cnt      = 3'd1;
    end else if (cp[20:11] == '0) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.cnt      = 3'd2;
    end else if (cp[20:16] == '0) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.cnt      = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.cnt      = 3'd4;
    end
    return e;
  endfunction

endpackage

>>> src/bsu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input byte channel
// Valid/ready channel carrying one raw file byte per word.
// ----------------------------------------------------------------------------
interface bsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

>>> src/bsu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output byte channel
// Valid/ready channel carrying one UTF-8 byte and its markers per word.
// ----------------------------------------------------------------------------
interface bsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_of_run;
  logic       end_of_text;

  modport source (output valid, output out_byte, output byte_valid,
                  output last_of_run, output end_of_text, input ready);
  modport sink (input valid, input out_byte, input byte_valid,
                input last_of_run, input end_of_text, output ready);
endinterface

>>> src/bsu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BOM sniffing front end
// Accepts raw bytes, tracks the mark and code unit state, and builds at most
// one bundle of up to four output bytes per input byte.
// ----------------------------------------------------------------------------
module bsu_front (
  input  logic             clk,
  input  logic             rst,
  bsu_in_if.sink           rx,
  input  logic             full,
  output logic             push,
  output bsu_pkg::bundle_t push_data
);
  import bsu_pkg::*;

  typedef enum logic [1:0] {
    MODE_UNDECIDED,
    MODE_PASS,
    MODE_LE,
    MODE_BE
  } mode_t;

  mode_t       mode, mode_next;
  logic [1:0]  seen, seen_next;
  logic [15:0] held, held_next;
  logic [7:0]  first, first_next;
  logic        half, half_next;
  logic [9:0]  pbits, pbits_next;
  logic        pend, pend_next;

  logic            accept;
  logic [7:0]      b;
  logic [15:0]     unit;
  logic [3:0][7:0] raw;
  logic [2:0]      raw_cnt;
  logic            cp_en;
  logic [20:0]     cp;
  enc_t            enc;

  assign rx.ready = !full;
  assign accept   = rx.valid && !full;
  assign b        = rx.in_byte;
  assign unit     = (mode == MODE_LE) ? {b, first} : {first, b};

  always_comb begin
    mode_next  = mode;
    seen_next  = seen;
    held_next  = held;
    first_next = first;
    half_next  = half;
    pbits_next = pbits;
    pend_next  = pend;
    raw        = '0;
    raw_cnt    = 3'd0;
    cp_en      = 1'b0;
    cp         = '0;
    unique case (mode)
      MODE_UNDECIDED: begin
        if (seen == 2'd0) begin
          if (b == BOM_EF || b == BOM_FF || b == BOM_FE) begin
            held_next = {8'h00, b};
            seen_next = 2'd1;
            if (rx.is_last) begin
              raw[0]  = b;
              raw_cnt = 3'd1;
            end
          end else begin
            mode_next = MODE_PASS;
            raw[0]    = b;
            raw_cnt   = 3'd1;
          end
        end else if (seen == 2'd1) begin
          if (held[7:0] == BOM_FF && b == BOM_FE) begin
            mode_next = MODE_LE;
          end else if (held[7:0] == BOM_FE && b == BOM_FF) begin
            mode_next = MODE_BE;
          end else if (held[7:0] == BOM_EF && b == BOM_BB) begin
            held_next = {held[7:0], b};
            seen_next = 2'd2;
            if (rx.is_last) begin
              raw[0]  = held[7:0];
              raw[1]  = b;
              raw_cnt = 3'd2;
            end
          end else begin
            mode_next = MODE_PASS;
            raw[0]    = held[7:0];
            raw[1]    = b;
            raw_cnt   = 3'd2;
          end
        end else begin
          mode_next = MODE_PASS;
          if (b != BOM_BF) begin
            raw[0]  = held[15:8];
            raw[1]  = held[7:0];
            raw[2]  = b;
            raw_cnt = 3'd3;
          end
        end
      end
      MODE_PASS: begin
        raw[0]  = b;
        raw_cnt = 3'd1;
      end
      MODE_LE, MODE_BE: begin
        if (half) begin
          half_next = 1'b0;
          if (pend) begin
            pend_next = 1'b0;
            cp_en     = 1'b1;
            if (unit[15:10] == LOW_SURR_TAG) begin
              cp = CP_SUPP_BASE + {1'b0, pbits, unit[9:0]};
            end else begin
              cp = CP_REPLACEMENT;
            end
          end else if (unit[15:10] == HIGH_SURR_TAG) begin
            pbits_next = unit[9:0];
            pend_next  = 1'b1;
          end else if (unit[15:10] == LOW_SURR_TAG) begin
            cp_en = 1'b1;
            cp    = CP_REPLACEMENT;
          end else begin
            cp_en = 1'b1;
            cp    = {5'b0, unit};
          end
        end else begin
          first_next = b;
          half_next  = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_UNDECIDED;
      end
    endcase

    if (rx.is_last && pend_next) begin
      cp_en = 1'b1;
      cp    = CP_REPLACEMENT;
    end
    if (rx.is_last) begin
      mode_next = MODE_UNDECIDED;
      seen_next = 2'd0;
      half_next = 1'b0;
      pend_next = 1'b0;
    end
  end

  assign enc = utf8_encode(cp);

  always_comb begin
    push_data.last  = rx.is_last;
    push_data.data  = 1'b1;
    push_data.bytes = cp_en ? enc.bytes : raw;
    push_data.cnt   = cp_en ? enc.cnt : raw_cnt;
    if (!cp_en && raw_cnt == 3'd0 && rx.is_last) begin
      push_data.bytes = '0;
      push_data.cnt   = 3'd1;
      push_data.data  = 1'b0;
    end
  end

  assign push = accept && (cp_en || raw_cnt != 3'd0 || rx.is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_UNDECIDED;
      seen <= 2'd0;
      half <= 1'b0;
      pend <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      seen <= seen_next;
      half <= half_next;
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held  <= held_next;
      first <= first_next;
      pbits <= pbits_next;
    end
  end

endmodule

>>> src/bsu_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bundle queue
// Short queue of result bundles between the front end and the serializer.
// ----------------------------------------------------------------------------
`include "bom_sniffing_utf16_to_utf8_assert.svh"

module bsu_fifo #(
  parameter int unsigned DEPTH = bsu_pkg::FifoDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bsu_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output bsu_pkg::bundle_t head
);
  import bsu_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bundle_t        slots [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  cnt;
  logic           do_push, do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `ASSERT_IMPLY(a_no_overflow, clk, rst, push, !full)
  `ASSERT_IMPLY(a_no_underflow, clk, rst, pop, !empty)
  `ASSERT_NEXT(a_push_lands, clk, rst, push && !pop, !empty)

endmodule

>>> src/bsu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte serializer
// Walks the head bundle one byte per word and marks run and stream ends.
// ----------------------------------------------------------------------------
`include "bom_sniffing_utf16_to_utf8_assert.svh"

module bsu_back (
  input  logic             clk,
  input  logic             rst,
  input  bsu_pkg::bundle_t head,
  input  logic             empty,
  output logic             pop,
  bsu_out_if.source        tx
);
  import bsu_pkg::*;

  logic [1:0] idx;
  logic       final_byte;

  assign final_byte     = ({1'b0, idx} + 3'd1) == head.cnt;
  assign tx.valid       = !empty;
  assign tx.out_byte    = head.bytes[idx];
  assign tx.byte_valid  = head.data;
  assign tx.last_of_run = final_byte;
  assign tx.end_of_text = final_byte && head.last;
  assign pop            = tx.valid && tx.ready && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (tx.valid && tx.ready) begin
      idx <= final_byte ? 2'd0 : idx + 2'd1;
    end
  end

  `ASSERT_NEXT(a_run_continues, clk, rst, tx.valid && tx.ready && !tx.last_of_run, tx.valid)
  `ASSERT_IMPLY(a_bare_marker, clk, rst, tx.valid && !tx.byte_valid, tx.end_of_text && idx == 2'd0)
  `ASSERT_IMPLY(a_idx_in_run, clk, rst, tx.valid, ({1'b0, idx} < head.cnt))

endmodule

>>> src/bom_sniffing_utf16_to_utf8.sv
`timescale 1ns / 1ps
// Timing: an item's first result byte is offered in the cycle after the byte is taken,
//   when the bundle queue and the serializer are idle.
// Throughput: one input byte per cycle while the bundle queue has room; output runs
//   at one byte per cycle while the sink is ready; an item yields up to 4 bytes.
// Sustained UTF-16 rate is set by the serializer: 2 input bytes yield up to 3 output bytes.
// Reset: synchronous active-high rst empties the queue and starts a new stream.
// ----------------------------------------------------------------------------
// BOM sniffing UTF-16 to UTF-8 transcoder
// Front end classifies bytes into result bundles, a queue decouples it from
// the serializer that drives the output channel.
// ----------------------------------------------------------------------------
module bom_sniffing_utf16_to_utf8 #(
  parameter int unsigned FIFO_DEPTH = bsu_pkg::FifoDepth
) (
  input  logic      clk,
  input  logic      rst,
  bsu_in_if.sink    rx,
  bsu_out_if.source tx
);
  import bsu_pkg::*;

  logic    push, full, pop, empty;
  bundle_t push_data, head;

  bsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  bsu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  bsu_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .tx    (tx)
  );

endmodule
